// ----- hdl/mmf_pkg.sv -----
// shared constants and codes for the fixed-point matrix multiply engine
package mmf_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 56;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

endpackage

// ----- hdl/matrix_multiply_fixed.sv -----
// fixed-point matrix multiply engine: element stores, shared multiply-accumulate sequencer
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | sink      | in_valid / in_ready  | mode, row_index, col_index, element_value
//  out     | source    | out_valid/out_ready  | out_row, out_col, out_value, out_last
//  cfg     | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data (4-bit dimension)
//
// load items are taken back to back; ready stays high while loading.
// a start item runs rows_a * cols_b result elements: read, multiply, accumulate per term,
// then finish. these steps share one 32x32 multiplier and one 58-bit adder.
// in_ready is low from the start transfer until the last result is in the output register.
// a stalled output holds the sequencer in its finish step; cfg_ready is always high.
// synchronous active-low reset clears control state; the element stores have no reset.
module matrix_multiply_fixed #(
  parameter int MAX_DIM   = mmf_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mmf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mmf_pkg::MODE_W-1:0]          in_mode,
  input  logic [mmf_pkg::POS_W-1:0]           in_row_index,
  input  logic [mmf_pkg::POS_W-1:0]           in_col_index,
  input  logic signed [mmf_pkg::DATA_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mmf_pkg::POS_W-1:0]           out_row,
  output logic [mmf_pkg::POS_W-1:0]           out_col,
  output logic signed [mmf_pkg::DATA_W-1:0]   out_value,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]           cfg_data
);
  import mmf_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = ACC_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // last index for a dimension register: zero acts as one, large values clamp
  function automatic logic [CNT_W-1:0] last_idx(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM - 1);
    end else begin
      r = CNT_W'(v - 1'b1);
    end
    return r;
  endfunction

  logic [2:0]                state_r, state_nxt;
  logic [CFG_W-1:0]          rows_a_r, inner_dim_r, cols_b_r;
  logic [CNT_W-1:0]          i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DATA_W-1:0]  a_rd_r, b_rd_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]          out_row_r, out_col_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic                      out_last_r;

  logic signed [DATA_W-1:0]  mem_a [DEPTH];
  logic signed [DATA_W-1:0]  mem_b [DEPTH];

  logic                      in_xfer, load_ok, out_free, fin_go, last_elem;
  logic [CNT_W-1:0]          nr_m1, nk_m1, nc_m1;
  logic [ADDR_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
  logic signed [SUM_W-1:0]   prod_sh, sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [DATA_W-1:0]  res_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  assign nr_m1 = last_idx(rows_a_r);
  assign nk_m1 = last_idx(inner_dim_r);
  assign nc_m1 = last_idx(cols_b_r);

  // loads outside the store are dropped
  assign load_ok = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
  assign wr_addr   = ADDR_W'(int'(in_row_index) * MAX_DIM + int'(in_col_index));
  assign rd_addr_a = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  always_ff @(posedge clk) begin
    if (in_xfer && load_ok && in_mode == MODE_LOAD_A) begin
      mem_a[wr_addr] <= in_element_value;
    end
    if (in_xfer && load_ok && in_mode == MODE_LOAD_B) begin
      mem_b[wr_addr] <= in_element_value;
    end
    a_rd_r <= mem_a[rd_addr_a];
    b_rd_r <= mem_b[rd_addr_b];
    if (state_r == S_MUL) begin
      prod_r <= a_rd_r * b_rd_r;
    end
  end

  // floor shift of the product, then saturating add into the accumulator
  assign prod_sh = SUM_W'(prod_r >>> FRAC_BITS);
  assign sum     = {{2{acc_r[ACC_W-1]}}, acc_r} + prod_sh;

  always_comb begin
    if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1) begin
      acc_sat = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = ACC_MAX;
    end
  end

  always_comb begin
    if (acc_r[ACC_W-1:DATA_W-1] == '0 || acc_r[ACC_W-1:DATA_W-1] == '1) begin
      res_sat = acc_r[DATA_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      res_sat = OUT_MIN;
    end else begin
      res_sat = OUT_MAX;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign fin_go    = (state_r == S_FIN) && out_free;
  assign last_elem = (i_r == nr_m1) && (j_r == nc_m1);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_mode == MODE_START) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_sat;
        if (k_r == nk_m1) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt   = '0;
            acc_nxt = '0;
            if (j_r == nc_m1) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS_A:    rows_a_r    <= cfg_data;
          CFG_INNER_DIM: inner_dim_r <= cfg_data;
          CFG_COLS_B:    cols_b_r    <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_row_r   <= POS_W'(i_r);
      out_col_r   <= POS_W'(j_r);
      out_value_r <= res_sat;
      out_last_r  <= last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// ----- hdl/mmf_checker.sv -----
// port-level checks for the matrix multiply engine, bound to the top level
module mmf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [mmf_pkg::MODE_W-1:0]          in_mode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mmf_pkg::DATA_W-1:0]   out_value,
  input logic                                out_last
);
  import mmf_pkg::*;

  // a start transfer takes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_START |=> !in_ready)
    else $error("in_ready still high after start transfer");

  // load transfers never block the input
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_LOAD_A || in_mode == MODE_LOAD_B)
    |=> in_ready)
    else $error("in_ready dropped after load transfer");

  // the block only frees up once the final result is presented
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid && out_last)
    else $error("in_ready rose without final result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_fixed mmf_checker u_mmf_checker (.*);
